>>> rtl/crsf_pkg.sv
// Shared types, constants and the CRC-8 byte fold for the frame builder.
// Used by the front, queue, back and top-level modules; no dependencies.
package crsf_pkg;

  localparam int unsigned MaxPayloadDefault = 60;
  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0] CrcPoly = 8'hD5;
  localparam logic [7:0] CrcTop = 8'h80;
  localparam logic [7:0] AddrReset = 8'hEA;
  localparam logic [7:0] LenOverhead = 8'd2;
  localparam int unsigned PaddrWidth = 3;
  localparam logic RegIdxAddress = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] len_byte;
    logic [7:0] crc;
    logic       start;
    logic       last;
  } item_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 8'd0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/crsf_front.sv
// Front end: accepts input requests, folds the CRC and forms queue entries.
// Depends on crsf_pkg.
module crsf_front
  import crsf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_start,
  input  logic [5:0] in_len,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_entry
);

  logic [7:0] running_crc;
  logic [7:0] running_crc_next;
  logic [7:0] crc_new;
  logic [7:0] len_ext;
  logic [7:0] len_max;
  logic [7:0] len_sat;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign len_ext = {2'b00, in_len};
  assign len_max = 8'(MAX_PAYLOAD);
  assign len_sat = (len_ext > len_max) ? len_max : len_ext;
  assign crc_new = crc_fold(in_start ? 8'd0 : running_crc, in_data);

  always_comb begin
    q_entry.data     = in_data;
    q_entry.len_byte = len_sat + LenOverhead;
    q_entry.crc      = crc_new;
    q_entry.start    = in_start;
    q_entry.last     = in_last;
  end

  assign running_crc_next = in_last ? 8'd0 : crc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= 8'd0;
    end else if (q_push) begin
      running_crc <= running_crc_next;
    end
  end

endmodule

>>> rtl/crsf_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on crsf_pkg.
module crsf_queue
  import crsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_entry,
  input  logic  pop,
  output logic  full,
  output logic  nonempty,
  output item_t head,
  output logic [$clog2(QueueDepth+1)-1:0] level
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(QueueDepth));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];
  assign level    = count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/crsf_back.sv
// Back end: serializes queue entries into header (start entry), data and CRC
// (last entry) bytes through a registered output stage. Depends on crsf_pkg.
module crsf_back
  import crsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  input  item_t      q_head,
  output logic       q_pop,
  input  logic [7:0] address_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end
);

  typedef enum logic [1:0] {
    POS_ADDR = 2'd0,
    POS_LEN  = 2'd1,
    POS_DATA = 2'd2,
    POS_CRC  = 2'd3
  } pos_t;

  logic [1:0] step;
  logic [1:0] step_next;
  pos_t       pos;
  pos_t       pos_final;
  logic       load;
  logic [7:0] byte_sel;

  assign load      = q_nonempty && (!out_valid || out_ready);
  assign pos       = pos_t'((q_head.start ? POS_ADDR : POS_DATA) + step);
  assign pos_final = q_head.last ? POS_CRC : POS_DATA;
  assign q_pop     = load && (pos == pos_final);
  assign step_next = q_pop ? 2'd0 : step + 2'd1;

  always_comb begin
    case (pos)
      POS_ADDR: byte_sel = address_byte;
      POS_LEN:  byte_sel = q_head.len_byte;
      POS_DATA: byte_sel = q_head.data;
      POS_CRC:  byte_sel = q_head.crc;
      default:  byte_sel = q_head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= step_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_sel;
      out_end  <= (pos == POS_CRC);
    end
  end

endmodule

>>> rtl/crsf_frame_builder.sv
// Top level of the serial frame builder with CRC-8 (polynomial 0xD5).
// Depends on crsf_pkg, crsf_front, crsf_queue and crsf_back.
//
// Input stream (s_*): one request per byte. A request with s_tuser set opens
// a frame and carries the type byte and payload length; s_tlast marks the
// last request of the frame. Output stream (m_*): the frame bytes in order,
// address, length, type, payload, then the CRC with m_tlast set.
// The APB port holds the address byte at byte addresses 0 to 3 (reset 0xEA).
//
// An accepted request passes through the queue and the output byte register
// before its first byte appears on m_*. The back end emits one byte per cycle
// while m_tready is high, so payload requests then flow at one per cycle; a
// start request yields three output bytes and a closing request one more. A
// four-entry queue lets the front keep accepting while header and CRC bytes
// are sent. When the receiver stalls, the output register holds and the queue
// fills, after which s_tready drops. Reset empties the queue, clears the
// running CRC and restores the address byte.
module crsf_frame_builder
  import crsf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,  // [7:0] data_byte, [13:8] payload_len, [15:14] zero
  input  logic                  s_tuser,  // [0] frame_start
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,  // [7:0] out_byte
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic       address_byte;
  logic [7:0] addr_reg;
  logic       reg_hit;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_nonempty;
  item_t      q_entry;
  item_t      q_head;
  logic [$clog2(QueueDepth+1)-1:0] q_level;

  assign pready       = 1'b1;
  assign reg_hit      = (paddr[PaddrWidth-1] == RegIdxAddress);
  assign address_byte = reg_hit;
  assign prdata       = address_byte ? {24'd0, addr_reg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_reg <= AddrReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      addr_reg <= pwdata[7:0];
    end
  end

  crsf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata[7:0]),
    .in_start (s_tuser),
    .in_len   (s_tdata[13:8]),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  crsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (q_head),
    .level      (q_level)
  );

  crsf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .address_byte (addr_reg),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (m_tdata),
    .out_end      (m_tlast)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("Queue level exceeds its depth.");

  a_ready_level: assert property (@(posedge clk) disable iff (rst)
    s_tready == (q_level != ($clog2(QueueDepth+1))'(QueueDepth)))
    else $error("Input ready does not follow queue occupancy.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && (q_level == '0))
    else $error("Output or queue not empty after reset.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty && !q_push || q_nonempty)
    else $error("Queue popped while empty.");

endmodule
